// ----- design/mgpl_pkg.sv -----
// shared types and constants of the masked grid point locator
package mgpl_pkg;

  // default sizes
  localparam int unsigned MASK_BITS_DEF = 64;
  localparam int unsigned MAX_STEPS_DEF = 63;

  // field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned STEPS_W    = 6;
  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned REF_LAT_W  = 31;
  localparam int unsigned REF_LON_W  = 32;
  localparam int unsigned SPACING_W  = 27;
  localparam int unsigned PROD_W     = STEPS_W + SPACING_W;
  localparam int unsigned ANGLE_W    = 40;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_STEPS  = 3'd0,
    REG_LON_STEPS  = 3'd1,
    REG_VALID_MASK = 3'd2,
    REG_REF_LAT    = 3'd3,
    REG_REF_LON    = 3'd4,
    REG_STEP_LAT   = 3'd5,
    REG_STEP_LON   = 3'd6
  } cfg_reg_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_MLAT = 6'b000100,
    ST_MLON = 6'b001000,
    ST_MADD = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

endpackage

// ----- design/masked_grid_point_locator.sv -----
// masked grid point locator: mask scan sequencer with a shared multiplier and adder
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | packed_index_i
//   out     | out       | out_valid_o/out_ready_i | found_o .. point_lon_o
//
// a beat is accepted, then scanned at one grid position per cycle (bounded by the grid
// size and the mask length); a hit then runs through the shared multiplier and adder
// in ST_MLAT, ST_MLON and ST_MADD, and ST_DONE loads the output register.
// the scan loop over the mask sets how long a beat takes.
// reset clears the configuration registers and the sequencer, no result pending.
// a finished result waits in the output register while the next beat is accepted;
// a new result waits in the last state only while the old one is still stalled.
module masked_grid_point_locator
  import mgpl_pkg::*;
#(
  parameter int unsigned MASK_BITS = MASK_BITS_DEF,
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [INDEX_W-1:0]        packed_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o,
  output logic [POS_W-1:0]          grid_position_o,
  output logic                      point_valid_o,
  output logic [STEPS_W-1:0]        row_o,
  output logic [STEPS_W-1:0]        column_o,
  output logic signed [ANGLE_W-1:0] point_lat_o,
  output logic signed [ANGLE_W-1:0] point_lon_o
);

  // configuration registers
  logic [STEPS_W-1:0]   lat_steps_q, lon_steps_q;
  logic [MASK_BITS-1:0] mask_q;
  logic [REF_LAT_W-1:0] ref_lat_q;
  logic [REF_LON_W-1:0] ref_lon_q;
  logic [SPACING_W-1:0] step_lat_q, step_lon_q;

  // sequencer and scan state
  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]   want_q, want_d;
  logic [INDEX_W-1:0]   seen_q, seen_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [STEPS_W-1:0]   row_q, row_d;
  logic [STEPS_W-1:0]   col_q, col_d;
  logic [MASK_BITS-1:0] shift_q, shift_d;
  logic                 hit_q, hit_d;
  logic                 ok_q, ok_d;

  // arithmetic path
  logic [STEPS_W-1:0]   mul_a;
  logic [SPACING_W-1:0] mul_b;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [ANGLE_W-1:0]   add_a, add_b, add_y;
  logic                 add_sub;
  logic [ANGLE_W-1:0]   lat_q, lat_d, lon_q, lon_d;

  logic [STEPS_W-1:0]   lat_n, lon_n;
  logic                 cur_ok, last_pos, past_mask, load_out;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_steps_q <= '0;
      lon_steps_q <= '0;
      mask_q      <= '0;
      ref_lat_q   <= '0;
      ref_lon_q   <= '0;
      step_lat_q  <= '0;
      step_lon_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LAT_STEPS:  lat_steps_q <= cfg_data_i[STEPS_W-1:0];
        REG_LON_STEPS:  lon_steps_q <= cfg_data_i[STEPS_W-1:0];
        REG_VALID_MASK: mask_q      <= cfg_data_i[MASK_BITS-1:0];
        REG_REF_LAT:    ref_lat_q   <= cfg_data_i[REF_LAT_W-1:0];
        REG_REF_LON:    ref_lon_q   <= cfg_data_i[REF_LON_W-1:0];
        REG_STEP_LAT:   step_lat_q  <= cfg_data_i[SPACING_W-1:0];
        REG_STEP_LON:   step_lon_q  <= cfg_data_i[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  // step counts clamped to the grid limit
  assign lat_n = (lat_steps_q > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : lat_steps_q;
  assign lon_n = (lon_steps_q > STEPS_W'(MAX_STEPS)) ? STEPS_W'(MAX_STEPS) : lon_steps_q;

  // mask shifts left one position per step, zeros fill past the mask
  assign cur_ok    = shift_q[MASK_BITS-1];
  assign last_pos  = (row_q == lat_n) && (col_q == lon_n);
  assign past_mask = (pos_q == POS_W'(MASK_BITS));

  // shared multiplier: row by lat spacing, then column by lon spacing
  always_comb begin
    if (state_q == ST_MLAT) begin
      mul_a = row_q;
      mul_b = step_lat_q;
    end else begin
      mul_a = col_q;
      mul_b = step_lon_q;
    end
  end

  // shared adder: lat subtracts, lon adds
  always_comb begin
    if (state_q == ST_MLON) begin
      add_a   = {{(ANGLE_W-REF_LAT_W){ref_lat_q[REF_LAT_W-1]}}, ref_lat_q};
      add_sub = 1'b1;
    end else begin
      add_a   = {{(ANGLE_W-REF_LON_W){ref_lon_q[REF_LON_W-1]}}, ref_lon_q};
      add_sub = 1'b0;
    end
    add_b = {{(ANGLE_W-PROD_W){1'b0}}, prod_q};
    add_y = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    want_d   = want_q;
    seen_d   = seen_q;
    pos_d    = pos_q;
    row_d    = row_q;
    col_d    = col_q;
    shift_d  = shift_q;
    hit_d    = hit_q;
    ok_d     = ok_q;
    prod_d   = prod_q;
    lat_d    = lat_q;
    lon_d    = lon_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          want_d  = packed_index_i;
          seen_d  = '0;
          pos_d   = '0;
          row_d   = '0;
          col_d   = '0;
          shift_d = mask_q;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (seen_q == want_q) begin
          hit_d   = 1'b1;
          ok_d    = cur_ok;
          state_d = ST_MLAT;
        end else if (last_pos || past_mask) begin
          // count can no longer reach the index
          hit_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          seen_d  = seen_q + INDEX_W'(cur_ok);
          shift_d = shift_q << 1;
          pos_d   = pos_q + POS_W'(1);
          if (col_q == lon_n) begin
            col_d = '0;
            row_d = row_q + STEPS_W'(1);
          end else begin
            col_d = col_q + STEPS_W'(1);
          end
        end
      end
      ST_MLAT: begin
        prod_d  = mul_a * mul_b;
        state_d = ST_MLON;
      end
      ST_MLON: begin
        lat_d   = add_y;
        prod_d  = mul_a * mul_b;
        state_d = ST_MADD;
      end
      ST_MADD: begin
        lon_d   = add_y;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    want_q  <= want_d;
    seen_q  <= seen_d;
    pos_q   <= pos_d;
    row_q   <= row_d;
    col_q   <= col_d;
    shift_q <= shift_d;
    hit_q   <= hit_d;
    ok_q    <= ok_d;
    prod_q  <= prod_d;
    lat_q   <= lat_d;
    lon_q   <= lon_d;
  end

  // output register, all zero on a miss
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_o         <= hit_q;
      grid_position_o <= hit_q ? pos_q : '0;
      point_valid_o   <= hit_q & ok_q;
      row_o           <= hit_q ? row_q : '0;
      column_o        <= hit_q ? col_q : '0;
      point_lat_o     <= hit_q ? lat_q : '0;
      point_lon_o     <= hit_q ? lon_q : '0;
    end
  end

endmodule

// ----- design/mgpl_checker.sv -----
// port level checks of the masked grid point locator, bound to the top level
module mgpl_checker
  import mgpl_pkg::*;
#(
  parameter int unsigned MASK_BITS = MASK_BITS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      found_o,
  input logic [POS_W-1:0]          grid_position_o,
  input logic                      point_valid_o,
  input logic [STEPS_W-1:0]        row_o,
  input logic [STEPS_W-1:0]        column_o,
  input logic signed [ANGLE_W-1:0] point_lat_o,
  input logic signed [ANGLE_W-1:0] point_lon_o
);

  // an accepted beat keeps the input closed for the scan
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still open after a beat was accepted");

  // a new result appears only while a beat is in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no beat in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(found_o) &&
      $stable(grid_position_o) && $stable(point_lat_o) && $stable(point_lon_o)))
    else $error("stalled result changed");

  // a miss reports zeros
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (grid_position_o == '0 && !point_valid_o &&
      row_o == '0 && column_o == '0 && point_lat_o == '0 && point_lon_o == '0))
    else $error("miss with nonzero fields");

  // a valid point lies inside the mask
  a_valid_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_valid_o) |-> (found_o && grid_position_o < POS_W'(MASK_BITS)))
    else $error("valid point outside the mask");

endmodule

bind masked_grid_point_locator mgpl_checker #(
  .MASK_BITS(MASK_BITS)
) u_mgpl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .found_o         (found_o),
  .grid_position_o (grid_position_o),
  .point_valid_o   (point_valid_o),
  .row_o           (row_o),
  .column_o        (column_o),
  .point_lat_o     (point_lat_o),
  .point_lon_o     (point_lon_o)
);

// ----- dv/tb_masked_grid_point_locator.sv -----
// self-checking testbench of the masked grid point locator
module tb_masked_grid_point_locator;
  import mgpl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // index with no register behind it
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int LIMIT_TIME  = 2_000_000;
  localparam int PRINT_CAP   = 30;

  typedef struct {
    logic                      found;
    logic [POS_W-1:0]          position;
    logic                      valid;
    logic [STEPS_W-1:0]        row;
    logic [STEPS_W-1:0]        column;
    logic signed [ANGLE_W-1:0] lat;
    logic signed [ANGLE_W-1:0] lon;
  } grid_point_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [INDEX_W-1:0]        packed_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      found;
  logic [POS_W-1:0]          grid_position;
  logic                      point_valid;
  logic [STEPS_W-1:0]        row;
  logic [STEPS_W-1:0]        column;
  logic signed [ANGLE_W-1:0] point_lat;
  logic signed [ANGLE_W-1:0] point_lon;

  // grid setup as the block should hold it
  logic [STEPS_W-1:0]          grid_lat_steps = '0;
  logic [STEPS_W-1:0]          grid_lon_steps = '0;
  logic [MASK_BITS_DEF-1:0]    grid_mask = '0;
  logic signed [REF_LAT_W-1:0] anchor_lat = '0;
  logic signed [REF_LON_W-1:0] anchor_lon = '0;
  logic [SPACING_W-1:0]        pitch_lat = '0;
  logic [SPACING_W-1:0]        pitch_lon = '0;

  logic [INDEX_W-1:0] query_q[$];
  reg_write_t         reg_write_q[$];
  grid_point_t        expected_points[$];

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   error_count = 0;
  int   queries_taken = 0;
  int   results_seen = 0;
  int   found_count = 0;
  int   reg_writes = 0;

  masked_grid_point_locator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .packed_index_i (packed_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .found_o        (found),
    .grid_position_o(grid_position),
    .point_valid_o  (point_valid),
    .row_o          (row),
    .column_o       (column),
    .point_lat_o    (point_lat),
    .point_lon_o    (point_lon)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    #LIMIT_TIME;
    $display("run limit of %0d time units reached", LIMIT_TIME);
    $display("tb_masked_grid_point_locator: FAIL");
    $finish;
  end

  // register write into the expected grid setup, unmapped index ignored
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LAT_STEPS:  grid_lat_steps = data[STEPS_W-1:0];
      REG_LON_STEPS:  grid_lon_steps = data[STEPS_W-1:0];
      REG_VALID_MASK: grid_mask = data[MASK_BITS_DEF-1:0];
      REG_REF_LAT:    anchor_lat = data[REF_LAT_W-1:0];
      REG_REF_LON:    anchor_lon = data[REF_LON_W-1:0];
      REG_STEP_LAT:   pitch_lat = data[SPACING_W-1:0];
      REG_STEP_LON:   pitch_lon = data[SPACING_W-1:0];
      default: ;
    endcase
  endfunction

  // row-major walk counting valid positions until the count reaches the index
  function automatic grid_point_t locate_point(input logic [INDEX_W-1:0] want);
    grid_point_t p;
    int          lat_n;
    int          lon_n;
    int          seen;
    int          pos;
    logic        ok;
    longint      lat_v;
    longint      lon_v;
    p = '{default: '0};
    lat_n = (grid_lat_steps > MAX_STEPS_DEF) ? MAX_STEPS_DEF : grid_lat_steps;
    lon_n = (grid_lon_steps > MAX_STEPS_DEF) ? MAX_STEPS_DEF : grid_lon_steps;
    seen = 0;
    for (int r = 0; r <= lat_n; r++) begin
      for (int c = 0; c <= lon_n; c++) begin
        pos = r * (lon_n + 1) + c;
        // positions past the mask are never valid
        ok = 1'b0;
        if (pos < MASK_BITS_DEF) begin
          ok = grid_mask[MASK_BITS_DEF - 1 - pos];
        end
        if (seen == int'(want)) begin
          lat_v = longint'(anchor_lat) - longint'(r) * longint'(pitch_lat);
          lon_v = longint'(anchor_lon) + longint'(c) * longint'(pitch_lon);
          p.found    = 1'b1;
          p.position = POS_W'(pos);
          p.valid    = ok;
          p.row      = STEPS_W'(r);
          p.column   = STEPS_W'(c);
          p.lat      = lat_v[ANGLE_W-1:0];
          p.lon      = lon_v[ANGLE_W-1:0];
          return p;
        end
        if (ok) begin
          seen++;
        end
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    error_count++;
  endtask

  // accepted beats: update setup, predict, check results
  always @(posedge clk) begin : monitor
    grid_point_t got;
    grid_point_t want;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        expected_points.push_back(locate_point(packed_index));
        queries_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{found, grid_position, point_valid, row, column, point_lat, point_lon};
        results_seen++;
        if (expected_points.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_points.pop_front();
          if (want.found) begin
            found_count++;
          end
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
          if (got.position !== want.position)
            report_mismatch($sformatf("grid_position %0d, expected %0d",
                                      got.position, want.position));
          if (got.valid !== want.valid)
            report_mismatch($sformatf("point_valid %0b, expected %0b", got.valid, want.valid));
          if (got.row !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
          if (got.column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d", got.column, want.column));
          if (got.lat !== want.lat)
            report_mismatch($sformatf("point_lat %0d, expected %0d", got.lat, want.lat));
          if (got.lon !== want.lon)
            report_mismatch($sformatf("point_lon %0d, expected %0d", got.lon, want.lon));
        end
      end
    end
  end

  // register write beats
  always @(negedge clk) begin : reg_driver
    reg_write_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_fire) begin
      if (reg_write_q.size() != 0) begin
        w = reg_write_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= w.index;
        cfg_data  <= w.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // query beats with random idle cycles
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (query_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        packed_index <= query_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_ready  <= ($urandom_range(99) >= recv_stall_pct);
      hold_count <= 0;
      if (!hold_req) begin
        hold_done <= 1'b0;
      end
    end
  end

  // write all seven registers and wait until every write beat is taken
  task automatic program_grid(input int unsigned lat_s, input int unsigned lon_s,
                              input logic [63:0] mask, input longint lat0,
                              input longint lon0, input int unsigned dlat,
                              input int unsigned dlon);
    reg_write_q.push_back('{REG_LAT_STEPS, 64'(lat_s)});
    reg_write_q.push_back('{REG_LON_STEPS, 64'(lon_s)});
    reg_write_q.push_back('{REG_VALID_MASK, mask});
    reg_write_q.push_back('{REG_REF_LAT, 64'(lat0)});
    reg_write_q.push_back('{REG_REF_LON, 64'(lon0)});
    reg_write_q.push_back('{REG_STEP_LAT, 64'(dlat)});
    reg_write_q.push_back('{REG_STEP_LON, 64'(dlon)});
    do @(posedge clk); while (reg_write_q.size() != 0 || cfg_valid);
  endtask

  // sender pause until every query is taken and every result is back
  task automatic await_quiet();
    do @(posedge clk); while (query_q.size() != 0 || in_valid);
    do @(negedge clk); while (expected_points.size() != 0);
    @(posedge clk);
  endtask

  // mostly indexes near the valid count, some anywhere in range
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 3) != 0) begin
      return INDEX_W'($urandom_range(0, $countones(grid_mask) + 1));
    end
    return INDEX_W'($urandom);
  endfunction

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct,
                              input bit long_hold);
    int unsigned ls;
    int unsigned lo;
    logic [63:0] mask;
    ls = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    // plain, sparse or dense masks
    case ($urandom_range(0, 2))
      0: mask = {$urandom, $urandom};
      1: mask = {$urandom, $urandom} & {$urandom, $urandom};
      default: mask = {$urandom, $urandom} | {$urandom, $urandom};
    endcase
    program_grid(ls, lo, mask,
                 longint'($urandom_range(0, 32'd1_800_000_000)) - 900_000_000,
                 longint'($urandom_range(0, 32'd3_600_000_000)) - 1_800_000_000,
                 $urandom_range(0, 100_000_000), $urandom_range(0, 100_000_000));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_req       = long_hold;
    repeat (n) query_q.push_back(pick_index());
    await_quiet();
    hold_req = 1'b0;
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: one point, nothing valid
    query_q = '{7'd0, 7'd1, 7'd127};
    await_quiet();

    // unmapped write first; full mask, largest grid, top references
    reg_write_q.push_back('{REG_NONE, '1});
    program_grid(63, 63, '1, 900_000_000, 1_800_000_000, 100_000_000, 100_000_000);
    query_q = '{7'd0, 7'd1, 7'd63, 7'd64, 7'd65, 7'd127};
    await_quiet();

    // single column, deepest row, bottom references
    program_grid(63, 0, '1, -900_000_000, -1_800_000_000, 100_000_000, 100_000_000);
    query_q = '{7'd0, 7'd63, 7'd64};
    await_quiet();

    // single row, farthest column
    program_grid(0, 63, '1, -900_000_000, 1_800_000_000, 100_000_000, 100_000_000);
    query_q = '{7'd32, 7'd63, 7'd64};
    await_quiet();

    // empty mask, zero spacing
    program_grid(5, 5, '0, 0, 0, 0, 0);
    query_q = '{7'd0, 7'd1, 7'd2};
    await_quiet();

    // every other position valid, trailing invalid point and no match
    program_grid(6, 6, 64'h5555_5555_5555_5555, 123_456_789, -987_654_321, 1, 100_000_000);
    query_q = '{7'd0, 7'd3, 7'd24, 7'd25};
    await_quiet();

    // random grids under each pacing mix, one with a long result hold-off
    random_phase(50, 0, 0, 1'b0);
    random_phase(50, 60, 0, 1'b0);
    random_phase(50, 0, 60, 1'b0);
    random_phase(50, 37, 37, 1'b0);
    random_phase(50, 0, 0, 1'b1);
    random_phase(50, 60, 0, 1'b0);
    random_phase(50, 0, 60, 1'b0);
    random_phase(50, 37, 37, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_points.size() != 0) begin
      $display("%0d expected results never arrived", expected_points.size());
    end
    $display("%0d queries over random and corner grids, %0d hits, %0d register writes",
             queries_taken, found_count, reg_writes);
    $display("%0d results checked, %0d mismatches", results_seen, error_count);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("tb_masked_grid_point_locator: PASS");
    end else begin
      $display("tb_masked_grid_point_locator: FAIL");
    end
    $finish;
  end

endmodule

// ----- masked_grid_point_locator.f -----
design/mgpl_pkg.sv
design/masked_grid_point_locator.sv
design/mgpl_checker.sv
dv/tb_masked_grid_point_locator.sv
